[rtl/tenc_pkg.sv]
// ----------------------------------------------------------------------------
// tenc_pkg: text encoding guesser shared definitions
// Window size, derived widths, byte constants and encoding codes.
// ----------------------------------------------------------------------------
package tenc_pkg;

  // Zero-density window in bytes
  localparam int unsigned WINDOW  = 4096;
  localparam int unsigned POS_MAX = WINDOW + 3;
  localparam int unsigned POS_W   = $clog2(POS_MAX + 1);
  localparam int unsigned CNT_W   = $clog2((WINDOW + 1) / 2 + 1);
  localparam int unsigned FRM_W   = $clog2(WINDOW + 1);
  localparam int unsigned CMP_W   = POS_W + 5;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_W   = 2;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned ODATA_W = 8;

  // density test: 20 * count > 9 * frame
  localparam int unsigned CNT_MUL = 20;
  localparam int unsigned FRM_MUL = 9;

  // byte order mark bytes
  localparam logic [BYTE_W-1:0] BYTE_FE = 8'hFE;
  localparam logic [BYTE_W-1:0] BYTE_FF = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_EF = 8'hEF;
  localparam logic [BYTE_W-1:0] BYTE_BB = 8'hBB;
  localparam logic [BYTE_W-1:0] BYTE_BF = 8'hBF;

  // bytes undefined in Windows-1252
  localparam logic [BYTE_W-1:0] BYTE_U81 = 8'h81;
  localparam logic [BYTE_W-1:0] BYTE_U8D = 8'h8D;
  localparam logic [BYTE_W-1:0] BYTE_U8F = 8'h8F;
  localparam logic [BYTE_W-1:0] BYTE_U90 = 8'h90;
  localparam logic [BYTE_W-1:0] BYTE_U9D = 8'h9D;

  // default encoding register codes
  localparam logic [CFG_W-1:0] DEF_MACROMAN = 2'd0;
  localparam logic [CFG_W-1:0] DEF_UTF8     = 2'd1;
  localparam logic [CFG_W-1:0] DEF_WIN1252  = 2'd2;

  typedef enum logic [CODE_W-1:0] {
    ENC_UTF16BE  = 3'd0,
    ENC_UTF16LE  = 3'd1,
    ENC_UTF8     = 3'd2,
    ENC_ASCII    = 3'd3,
    ENC_MACROMAN = 3'd4,
    ENC_WIN1252  = 3'd5
  } enc_e;

endpackage

[rtl/text_encoding_guesser.sv]
// ----------------------------------------------------------------------------
// text_encoding_guesser
// Sniffs a byte stream (BOM, UTF-16 zero density, ASCII, fallback) and emits
// one encoding code word per stream on its final byte.
// ----------------------------------------------------------------------------
// Path: a byte is held in the input register; the code word is registered in the
//   result register when the final byte leaves the input register, then shown on m_axis.
// Throughput: one byte per cycle; the per-byte state update is the loop.
//   The input only stalls when a final byte meets a code word not yet taken.
// Reset: stream state cleared, default_encoding = UTF-8, no clearing pass.
module text_encoding_guesser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: default_encoding
  input  logic                          cfg_wr_en_i,
  input  logic [tenc_pkg::CFG_W-1:0]    cfg_wr_data_i,
  // byte stream in
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [tenc_pkg::BYTE_W-1:0]   s_axis_tdata_i,   // [7:0] byte_value
  input  logic                          s_axis_tlast_i,   // end_of_stream
  // encoding code out
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [tenc_pkg::ODATA_W-1:0]  m_axis_tdata_o    // [2:0] encoding_code
);

  import tenc_pkg::*;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]  def_q;

  // input register
  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_last_q;

  // per-stream state
  logic [POS_W-1:0]  pos_q,    pos_d;
  logic [CNT_W-1:0]  even_q,   even_d;
  logic [CNT_W-1:0]  odd_q,    odd_d;
  logic [BYTE_W-1:0] first_q,  first_d;
  logic [BYTE_W-1:0] second_q, second_d;
  logic              mark_q,   mark_d;
  logic              high_q,   high_d;
  logic              undef_q,  undef_d;

  // result register
  logic              out_valid_q;
  logic [CODE_W-1:0] out_code_q;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  // Only a final byte needs room in the result register; plain bytes always
  // move on, so the input register drains even while a result waits.
  logic advance, fire, in_acc, out_acc;

  assign advance         = !in_last_q || !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc         = out_valid_q && m_axis_tready_i;

  // --------------------------------------------------------------------------
  // State update for the byte in the input register
  // --------------------------------------------------------------------------
  logic in_window, is_zero, is_undef;

  assign in_window = pos_q < POS_W'(WINDOW);
  assign is_zero   = in_byte_q == '0;
  assign is_undef  = (in_byte_q == BYTE_U81) || (in_byte_q == BYTE_U8D) ||
                     (in_byte_q == BYTE_U8F) || (in_byte_q == BYTE_U90) ||
                     (in_byte_q == BYTE_U9D);

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    mark_d   = mark_q;
    if (pos_q == POS_W'(0)) begin
      first_d = in_byte_q;
    end else if (pos_q == POS_W'(1)) begin
      second_d = in_byte_q;
    end else if (pos_q == POS_W'(2)) begin
      mark_d = (first_q == BYTE_EF) && (second_q == BYTE_BB) && (in_byte_q == BYTE_BF);
    end

    even_d = even_q;
    odd_d  = odd_q;
    if (in_window && is_zero) begin
      if (pos_q[0]) odd_d  = odd_q + CNT_W'(1);
      else          even_d = even_q + CNT_W'(1);
    end

    high_d  = high_q || in_byte_q[BYTE_W-1];
    undef_d = undef_q || is_undef;

    // saturates at WINDOW+3: enough to tell short streams apart
    pos_d = (pos_q < POS_W'(POS_MAX)) ? pos_q + POS_W'(1) : pos_q;
  end

  // --------------------------------------------------------------------------
  // Decision, taken on the updated state of a final byte
  // --------------------------------------------------------------------------
  logic [FRM_W-1:0] frame;
  logic [CMP_W-1:0] even_x, odd_x, frame_x;
  logic             len_ge2, len_ge3;
  enc_e             code_d;

  assign frame   = (pos_d < POS_W'(WINDOW)) ? FRM_W'(pos_d) : FRM_W'(WINDOW);
  assign even_x  = CMP_W'(even_d) * CMP_W'(CNT_MUL);
  assign odd_x   = CMP_W'(odd_d)  * CMP_W'(CNT_MUL);
  assign frame_x = CMP_W'(frame)  * CMP_W'(FRM_MUL);
  assign len_ge2 = pos_d >= POS_W'(2);
  assign len_ge3 = pos_d >= POS_W'(3);

  always_comb begin
    priority if (len_ge2 && first_d == BYTE_FE && second_d == BYTE_FF) begin
      code_d = ENC_UTF16BE;
    end else if (len_ge2 && first_d == BYTE_FF && second_d == BYTE_FE) begin
      code_d = ENC_UTF16LE;
    end else if (len_ge3 && mark_d) begin
      code_d = ENC_UTF8;
    end else if (even_x > frame_x) begin
      code_d = ENC_UTF16BE;
    end else if (odd_x > frame_x) begin
      code_d = ENC_UTF16LE;
    end else if (!high_d) begin
      code_d = ENC_ASCII;
    end else begin
      unique case (def_q)
        DEF_MACROMAN: code_d = ENC_MACROMAN;
        DEF_WIN1252:  code_d = undef_d ? ENC_MACROMAN : ENC_WIN1252;
        default:      code_d = ENC_UTF8;  // UTF-8 and the unused code
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequential
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_q <= DEF_UTF8;
    end else if (cfg_wr_en_i) begin
      def_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      even_q   <= '0;
      odd_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
      mark_q   <= 1'b0;
      high_q   <= 1'b0;
      undef_q  <= 1'b0;
    end else if (fire) begin
      if (in_last_q) begin
        // stream done: start over
        pos_q    <= '0;
        even_q   <= '0;
        odd_q    <= '0;
        first_q  <= '0;
        second_q <= '0;
        mark_q   <= 1'b0;
        high_q   <= 1'b0;
        undef_q  <= 1'b0;
      end else begin
        pos_q    <= pos_d;
        even_q   <= even_d;
        odd_q    <= odd_d;
        first_q  <= first_d;
        second_q <= second_d;
        mark_q   <= mark_d;
        high_q   <= high_d;
        undef_q  <= undef_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_last_q) begin
      out_code_q <= code_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = ODATA_W'(out_code_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(POS_MAX))
    else $error("byte position past saturation");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (POS_W'(even_q) + POS_W'(odd_q)) <= pos_q)
    else $error("zero counts exceed bytes seen");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_q |=> pos_q == '0 && m_axis_tvalid_o)
    else $error("final byte did not restart stream and post result");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_code_q <= ENC_WIN1252)
    else $error("encoding code out of range");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |-> !(fire && in_last_q))
    else $error("result overwritten while waiting");

endmodule
